// ===== rtl/u2u8_pkg.sv =====
// Shared types and constants for the UCS-2 to UTF-8 name encoder.
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam int CAPACITY_LIMIT_DEFAULT = 256;
  localparam int CAP_W                  = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [15:0] UNIT_NUL   = 16'h0000;
  localparam logic [15:0] UNIT_NONCH = 16'hFFFF;
  localparam logic [15:0] LIM_ONE    = 16'h0080;
  localparam logic [15:0] LIM_TWO    = 16'h0800;

  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam int MAX_BYTES = 4;

  // One item's worth of output bytes, loaded into the emit buffer at once.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;   // NUL slot is left zero
    logic [2:0]                num;     // 1..4 bytes to send
    logic                      has_nul; // last byte is the terminator
  } result_t;

endpackage

// ===== rtl/u2u8_encode.sv =====
// Combinational UTF-8 encoding and string-state update for one code unit.
`timescale 1ns / 1ps

module u2u8_encode #(
  parameter int CAPACITY_LIMIT = u2u8_pkg::CAPACITY_LIMIT_DEFAULT
) (
  input  logic [15:0]                       code_unit,
  input  logic                              last_unit,
  input  logic [$clog2(CAPACITY_LIMIT)-1:0] count,
  input  logic                              closed,
  input  logic [u2u8_pkg::CAP_W-1:0]        out_capacity,
  output u2u8_pkg::result_t                 res,
  output logic                              has_result,
  output logic [$clog2(CAPACITY_LIMIT)-1:0] count_next,
  output logic                              closed_next
);

  localparam int CW = $clog2(CAPACITY_LIMIT);
  localparam int SW = ((CW > u2u8_pkg::CAP_W) ? CW : u2u8_pkg::CAP_W) + 2;

  logic [SW-1:0] cap;
  logic [SW-1:0] sum_need;
  logic [SW-1:0] sum_after;
  logic [1:0]    need;
  logic [CW-1:0] count_after;
  logic          term;
  logic          emit;
  logic          finish;

  // effective capacity: clamp to the limit, zero counts as one
  always_comb begin
    if (SW'(out_capacity) > SW'(CAPACITY_LIMIT)) begin
      cap = SW'(CAPACITY_LIMIT);
    end else if (out_capacity == '0) begin
      cap = SW'(1);
    end else begin
      cap = SW'(out_capacity);
    end
  end

  always_comb begin
    if (code_unit < u2u8_pkg::LIM_ONE) begin
      need = 2'd1;
    end else if (code_unit < u2u8_pkg::LIM_TWO) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
  end

  assign term     = (code_unit == u2u8_pkg::UNIT_NUL) || (code_unit == u2u8_pkg::UNIT_NONCH);
  assign sum_need = SW'(count) + SW'(need);
  assign emit     = !term && (sum_need < cap);

  assign count_after = emit ? CW'(sum_need) : count;
  assign sum_after   = SW'(count_after) + SW'(1);
  assign finish      = !emit || last_unit || (sum_after >= cap);

  always_comb begin
    res.bytes = '0;
    case (need)
      2'd1: begin
        res.bytes[0] = code_unit[7:0];
      end
      2'd2: begin
        res.bytes[0] = u2u8_pkg::LEAD_TWO | {3'b000, code_unit[10:6]};
        res.bytes[1] = u2u8_pkg::CONT_MARK | (code_unit[7:0] & u2u8_pkg::CONT_MASK);
      end
      default: begin
        res.bytes[0] = u2u8_pkg::LEAD_THREE | {4'b0000, code_unit[15:12]};
        res.bytes[1] = u2u8_pkg::CONT_MARK | (code_unit[13:6] & u2u8_pkg::CONT_MASK);
        res.bytes[2] = u2u8_pkg::CONT_MARK | (code_unit[7:0] & u2u8_pkg::CONT_MASK);
      end
    endcase
    if (!emit) begin
      res.bytes = '0;
    end
    res.num     = (emit ? {1'b0, need} : 3'd0) + {2'b00, finish};
    res.has_nul = finish;
  end

  always_comb begin
    if (closed) begin
      has_result  = 1'b0;
      count_next  = last_unit ? '0 : count;
      closed_next = !last_unit;
    end else begin
      has_result = 1'b1;
      if (finish && last_unit) begin
        count_next  = '0;
        closed_next = 1'b0;
      end else begin
        count_next  = count_after;
        closed_next = finish;
      end
    end
  end

endmodule

// ===== rtl/u2u8_emit.sv =====
// Result buffer that sends one item's bytes one beat at a time.
`timescale 1ns / 1ps

module u2u8_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u2u8_pkg::result_t load_res,
  output logic              take_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              string_end,
  output logic              run_last
);

  u2u8_pkg::result_t buf_res;
  logic              full;
  logic [1:0]        idx;
  logic              at_last;
  logic              fire;

  assign at_last = ({1'b0, idx} == (buf_res.num - 3'd1));
  assign fire    = full && !out_stall;
  assign take_ok = !full || (fire && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (at_last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_res <= load_res;
    end
  end

  assign out_valid  = full;
  assign out_byte   = buf_res.bytes[idx];
  assign run_last   = at_last;
  assign string_end = at_last && buf_res.has_nul;

endmodule

// ===== rtl/ucs2_to_utf8_name_encoder_core.sv =====
// Top level of the UCS-2 to UTF-8 name encoder.
`timescale 1ns / 1ps

// Converts a stream of UCS-2 code units into UTF-8 bytes, one byte per output beat.
// Input beat: code_unit plus last_unit, which marks the final unit of a string.
// Output beat: out_byte, string_end on the terminating NUL, run_last on the final
// byte produced by one input unit. Units 0x0000 and 0xFFFF, or a unit that would
// overflow out_capacity (one byte kept for the NUL), end the string with a NUL;
// later units are dropped until last_unit, which restarts the byte count.
// The cfg channel writes out_capacity (reset value 256); it is always ready and
// must only be written while the block is idle.
// Timing: a unit is encoded in the cycle it is accepted and its bytes land in a
// four-byte result buffer; the first byte is valid the next cycle. A unit giving
// 1 to 4 bytes holds the input until its last byte has left the single-byte output
// port; the next unit is taken in the same cycle the last byte leaves, so the
// stream runs with no gap. Dropped units give no bytes and go at one per cycle
// once the buffer has drained. When out_stall is high the current byte holds and
// in_stall rises once the buffer cannot drain. Reset (rst, synchronous) empties
// the buffer, clears the byte count and opens a new string.
module ucs2_to_utf8_name_encoder_core #(
  parameter int CAPACITY_LIMIT = u2u8_pkg::CAPACITY_LIMIT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                code_unit,
  input  logic                       last_unit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       string_end,
  output logic                       run_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [u2u8_pkg::CAP_W-1:0] cfg_data
);

  localparam int CW = $clog2(CAPACITY_LIMIT);

  logic [u2u8_pkg::CAP_W-1:0] out_capacity;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       closed;
  logic                       closed_next;
  u2u8_pkg::result_t          res;
  logic                       has_result;
  logic                       take_ok;
  logic                       in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = !take_ok;
  assign in_fire   = in_valid && take_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= u2u8_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  // string state moves once per accepted unit
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      closed <= 1'b0;
    end else if (in_fire) begin
      count  <= count_next;
      closed <= closed_next;
    end
  end

  u2u8_encode #(
    .CAPACITY_LIMIT(CAPACITY_LIMIT)
  ) u_encode (
    .code_unit   (code_unit),
    .last_unit   (last_unit),
    .count       (count),
    .closed      (closed),
    .out_capacity(out_capacity),
    .res         (res),
    .has_result  (has_result),
    .count_next  (count_next),
    .closed_next (closed_next)
  );

  u2u8_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire && has_result),
    .load_res  (res),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .string_end(string_end),
    .run_last  (run_last)
  );

endmodule
